// ----- rtl/edge_hint_ease_return_animator_assert.svh -----
// Assertion macros for the edge hint animator. The asserting module supplies clk and arst_n.
`ifndef EDGE_HINT_EASE_RETURN_ANIMATOR_ASSERT_SVH
`define EDGE_HINT_EASE_RETURN_ANIMATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define EHERA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define EHERA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/ehera_pkg.sv -----
package ehera_pkg;

	// item kinds
	localparam logic [1:0] KIND_DRAG    = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_TICK    = 2'd2;
	localparam logic [1:0] KIND_FRAME   = 2'd3;

	// shared multiplier operand selects, one per pass of the easing chain
	localparam logic [2:0] MSEL_SCALE = 3'd0;	// elapsed * reciprocal of duration
	localparam logic [2:0] MSEL_BACK  = 3'd1;	// quotient * duration, for the remainder
	localparam logic [2:0] MSEL_SQ    = 3'd2;	// t * t
	localparam logic [2:0] MSEL_CUBE  = 3'd3;	// t^2 * (3072 - 2t)
	localparam logic [2:0] MSEL_EXT   = 3'd4;	// start extent * (1024 - eased)

	localparam int MUL_A_W     = 26;
	localparam int MUL_B_W     = 12;
	localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
	localparam int RECIP_SHIFT = 20;
	localparam int T_W         = 11;

	localparam int STEP_CAP_MS = 32;
	localparam int UNIT_ONE    = 1024;
	localparam int SMOOTH_K    = 3072;
	localparam int EXTENT_BASE = 24;
	localparam int OFFSET_MAX  = 24;
	localparam int ROW_MIN     = 40;
	localparam int ROW_MAX     = 360;
	localparam int ROW_TOP_OFS = 36;

	typedef struct packed {
		logic       latch;
		logic       exec;
		logic       mul_en;
		logic [2:0] mul_sel;
		logic       wb;
		logic       load_out;
	} ehera_cmd_t;

	typedef struct packed {
		logic step_go;
	} ehera_sts_t;

endpackage

// ----- rtl/ehera_ctrl.sv -----
module ehera_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  ehera_pkg::ehera_sts_t sts,
	output ehera_pkg::ehera_cmd_t cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_EXEC = 4'd1;
	localparam logic [3:0] S_M1   = 4'd2;
	localparam logic [3:0] S_M2   = 4'd3;
	localparam logic [3:0] S_M3   = 4'd4;
	localparam logic [3:0] S_M4   = 4'd5;
	localparam logic [3:0] S_M5   = 4'd6;
	localparam logic [3:0] S_WB   = 4'd7;
	localparam logic [3:0] S_FIN  = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.latch    = in_valid && in_ready;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_EXEC;
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.step_go ? S_M1 : S_FIN;
			end
			S_M1: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = ehera_pkg::MSEL_SCALE;
				state_d     = S_M2;
			end
			S_M2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = ehera_pkg::MSEL_BACK;
				state_d     = S_M3;
			end
			S_M3: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = ehera_pkg::MSEL_SQ;
				state_d     = S_M4;
			end
			S_M4: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = ehera_pkg::MSEL_CUBE;
				state_d     = S_M5;
			end
			S_M5: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = ehera_pkg::MSEL_EXT;
				state_d     = S_WB;
			end
			S_WB: begin
				cmd.wb  = 1'b1;
				state_d = S_FIN;
			end
			S_FIN: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/ehera_dp.sv -----
module ehera_dp #(
	parameter int RETURN_MS  = 300,
	parameter int VIEW_WIDTH = 48
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ehera_pkg::ehera_cmd_t cmd,
	output ehera_pkg::ehera_sts_t sts,
	input  logic                  cfg_we,
	input  logic [11:0]           cfg_data,
	input  logic [1:0]            kind,
	input  logic                  from_left,
	input  logic signed [12:0]    drag_distance,
	input  logic [9:0]            touch_row,
	input  logic [15:0]           tick_gap_ms,
	output logic                  shown,
	output logic                  at_left,
	output logic [11:0]           x_position,
	output logic [8:0]            y_position,
	output logic [5:0]            extent,
	output logic                  returning
);

	localparam int AW = ehera_pkg::MUL_A_W;
	localparam int BW = ehera_pkg::MUL_B_W;
	localparam int PW = ehera_pkg::MUL_P_W;
	localparam int TW = ehera_pkg::T_W;
	localparam int RS = ehera_pkg::RECIP_SHIFT;
	localparam int EW = $clog2(RETURN_MS + 1);
	localparam int NW = EW + 10;
	localparam longint unsigned RECIP_L = (64'd1 << 30) / RETURN_MS;
	localparam logic [AW-1:0] RECIP = AW'(RECIP_L);
	localparam logic [EW-1:0] RET_V = EW'(RETURN_MS);
	localparam logic [11:0] VIEW_V = 12'(VIEW_WIDTH);

	// pull distance / 5, clamped to 0..24
	function automatic logic [4:0] drag_offset(input logic signed [12:0] d);
		logic [14:0] p;
		logic [4:0]  r;
		p = 15'(d[6:0]) * 15'd205;
		if (d[12]) r = 5'd0;
		else if (d >= 13'sd120) r = 5'(ehera_pkg::OFFSET_MAX);
		else r = p[14:10];
		return r;
	endfunction

	logic [11:0]        screen_width_q;
	logic [1:0]         kind_q;
	logic               from_left_q;
	logic signed [12:0] dist_q;
	logic [9:0]         row_q;
	logic [15:0]        gap_q;

	logic        left_q, vis_q, ret_q, fp_q;
	logic [5:0]  cur_q, start_q;
	logic [EW-1:0] elapsed_q;
	logic [8:0]  top_q;
	logic [11:0] xpos_q;

	logic [PW-1:0] prod_q;
	logic [TW-1:0] q_q, t_q;

	logic [9:0]    row_c;
	logic [5:0]    gap_c;
	logic [EW:0]   sum_c;
	logic [EW-1:0] elapsed_c;
	logic [11:0]   xpos_c;
	logic [AW-1:0] mul_a;
	logic [BW-1:0] mul_b;
	logic [TW-1:0] q_c, t_c, eased_c;
	logic [NW-1:0] rem_c;
	logic [11:0]   w_c;

	assign sts.step_go = (kind_q == ehera_pkg::KIND_TICK) && ret_q && !fp_q
		&& (elapsed_q < RET_V);

	always_comb begin
		if (row_q < 10'(ehera_pkg::ROW_MIN)) row_c = 10'(ehera_pkg::ROW_MIN);
		else if (row_q > 10'(ehera_pkg::ROW_MAX)) row_c = 10'(ehera_pkg::ROW_MAX);
		else row_c = row_q;

		gap_c = (gap_q > 16'(ehera_pkg::STEP_CAP_MS)) ? 6'(ehera_pkg::STEP_CAP_MS)
			: gap_q[5:0];
		sum_c = {1'b0, elapsed_q} + (EW+1)'(gap_c);
		elapsed_c = (sum_c > {1'b0, RET_V}) ? RET_V : sum_c[EW-1:0];

		if (from_left_q) xpos_c = 12'd0;
		else if (screen_width_q >= VIEW_V) xpos_c = screen_width_q - VIEW_V;
		else xpos_c = 12'd0;

		// easing chain intermediates
		q_c     = prod_q[RS +: TW];
		rem_c   = {elapsed_q, 10'd0} - prod_q[NW-1:0];
		t_c     = q_q + TW'(rem_c >= NW'(RETURN_MS));
		w_c     = 12'(ehera_pkg::SMOOTH_K) - {t_q, 1'b0};
		eased_c = prod_q[RS +: TW];

		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_sel)
			ehera_pkg::MSEL_SCALE: begin
				mul_a = RECIP;
				mul_b = BW'(elapsed_q);
			end
			ehera_pkg::MSEL_BACK: begin
				mul_a = AW'(q_c);
				mul_b = BW'(RETURN_MS);
			end
			ehera_pkg::MSEL_SQ: begin
				mul_a = AW'(t_c);
				mul_b = BW'(t_c);
			end
			ehera_pkg::MSEL_CUBE: begin
				mul_a = AW'(prod_q[20:0]);
				mul_b = w_c;
			end
			ehera_pkg::MSEL_EXT: begin
				mul_a = AW'(TW'(ehera_pkg::UNIT_ONE) - eased_c);
				mul_b = BW'(start_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// shared multiplier and its intermediates
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= PW'(mul_a) * PW'(mul_b);
			if (cmd.mul_sel == ehera_pkg::MSEL_BACK) q_q <= q_c;
			if (cmd.mul_sel == ehera_pkg::MSEL_SQ) t_q <= t_c;
		end
		if (cmd.latch) begin
			kind_q      <= kind;
			from_left_q <= from_left;
			dist_q      <= drag_distance;
			row_q       <= touch_row;
			gap_q       <= tick_gap_ms;
		end
		if (cmd.load_out) begin
			shown      <= vis_q;
			at_left    <= left_q;
			x_position <= xpos_q;
			y_position <= top_q;
			extent     <= cur_q;
			returning  <= ret_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q <= 12'd800;
			left_q    <= 1'b0;
			vis_q     <= 1'b0;
			ret_q     <= 1'b0;
			fp_q      <= 1'b0;
			cur_q     <= 6'd0;
			start_q   <= 6'd0;
			elapsed_q <= '0;
			top_q     <= 9'd0;
			xpos_q    <= 12'd0;
		end else begin
			if (cfg_we) screen_width_q <= cfg_data;
			if (cmd.wb) cur_q <= prod_q[10 +: 6];
			if (cmd.exec) begin
				case (kind_q)
					ehera_pkg::KIND_DRAG: begin
						ret_q  <= 1'b0;
						fp_q   <= 1'b0;
						left_q <= from_left_q;
						xpos_q <= xpos_c;
						cur_q  <= 6'(ehera_pkg::EXTENT_BASE) + 6'(drag_offset(dist_q));
						top_q  <= 9'(row_c - 10'(ehera_pkg::ROW_TOP_OFS));
						vis_q  <= 1'b1;
					end
					ehera_pkg::KIND_RELEASE: begin
						if (vis_q && !ret_q) begin
							ret_q     <= 1'b1;
							start_q   <= cur_q;
							elapsed_q <= '0;
							fp_q      <= 1'b0;
						end
					end
					ehera_pkg::KIND_TICK: begin
						if (ret_q && !fp_q) begin
							if (elapsed_q < RET_V) begin
								elapsed_q <= elapsed_c;
								fp_q      <= 1'b1;
							end else begin
								vis_q <= 1'b0;
								ret_q <= 1'b0;
							end
						end
					end
					ehera_pkg::KIND_FRAME: begin
						if (ret_q && fp_q) fp_q <= 1'b0;
					end
					default: begin
						fp_q <= fp_q;
					end
				endcase
			end
		end
	end

endmodule

// ----- rtl/edge_hint_ease_return_animator.sv -----
// Swipe-edge hint overlay controller. Each accepted input word (drag, release, timer tick or
// frame-drawn acknowledge) yields exactly one output word showing the overlay state after it.
// Drag, release, frame words and ticks that do not advance the return go from the accepting
// cycle through execute to the output load, which waits while the output register is still
// full; a tick that advances the return adds five passes of the easing chain through the
// one shared 26x12 multiplier plus write-back before the load.
// The next input word is taken as soon as the previous one sits in the output register.
// screen_width may be written at any time the block is idle; it affects drags only, from the next one on.
`include "edge_hint_ease_return_animator_assert.svh"

module edge_hint_ease_return_animator #(
	parameter int RETURN_MS  = 300,
	parameter int VIEW_WIDTH = 48
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write channel: screen_width
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [11:0]        cfg_data,
	// input channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         kind,
	input  logic               from_left,
	input  logic signed [12:0] drag_distance,
	input  logic [9:0]         touch_row,
	input  logic [15:0]        tick_gap_ms,
	// output channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic               shown,
	output logic               at_left,
	output logic [11:0]        x_position,
	output logic [8:0]         y_position,
	output logic [5:0]         extent,
	output logic               returning
);

	ehera_pkg::ehera_cmd_t cmd;
	ehera_pkg::ehera_sts_t sts;

	// configuration is a plain register write, always taken
	assign cfg_ready = 1'b1;

	// sequencer: accept, execute, easing passes, write-back, output load
	ehera_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// overlay state, drag geometry and the eased extent chain
	ehera_dp #(
		.RETURN_MS  (RETURN_MS),
		.VIEW_WIDTH (VIEW_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.kind          (kind),
		.from_left     (from_left),
		.drag_distance (drag_distance),
		.touch_row     (touch_row),
		.tick_gap_ms   (tick_gap_ms),
		.shown         (shown),
		.at_left       (at_left),
		.x_position    (x_position),
		.y_position    (y_position),
		.extent        (extent),
		.returning     (returning)
	);

	// one word in flight: drop ready right after an accept
	`EHERA_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
	// a return only runs on a visible overlay
	`EHERA_ASSERT_NOW(a_return_visible, out_valid && returning, shown, "return while hidden")
	// the eased extent never exceeds the full capsule
	`EHERA_ASSERT_NOW(a_extent_range, out_valid, extent <= 6'd48, "extent out of range")

endmodule
